>>> sv/lrast_pkg.sv
// ----------------------------------------------------------------------------
// lrast_pkg
// Shared constants for the range-add / range-sum store.
// ----------------------------------------------------------------------------
package lrast_pkg;

	localparam int CAPACITY = 65536;
	localparam int IDX_W    = 16;
	localparam int N_W      = 17;
	localparam int DEPTH    = 2 * CAPACITY;
	localparam int ADDR_W   = $clog2(DEPTH);
	localparam int SUM_W    = 64;

	// operation codes
	localparam logic [1:0] OP_ADD   = 2'd0;
	localparam logic [1:0] OP_POINT = 2'd1;
	localparam logic [1:0] OP_SUM   = 2'd2;
	localparam logic [1:0] OP_RSVD  = 2'd3;

endpackage

>>> sv/lrast_ram.sv
// ----------------------------------------------------------------------------
// lrast_ram
// Generic single-port RAM with registered read data.
// ----------------------------------------------------------------------------
module lrast_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// one access per cycle, read data registered
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end

endmodule

>>> sv/lazy_range_add_segment_tree_top.sv
// ----------------------------------------------------------------------------
// lazy_range_add_segment_tree_top
// Range add, point query and range sum over up to 65536 signed 64-bit sums.
// ----------------------------------------------------------------------------
// Range add: two index walks, a read then a write per node.
// Sum or point query: two prefix walks plus a 17-step shift-add multiply
//   each; one operation at a time, set by the single RAM port.
// Reset and every configuration write start a clearing pass over all 131072
//   RAM words with in_ready low; configuration writes are taken at any time.
module lazy_range_add_segment_tree_top (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [lrast_pkg::N_W-1:0]    cfg_data,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [1:0]                   op,
	input  logic [lrast_pkg::IDX_W-1:0]  left,
	input  logic [lrast_pkg::IDX_W-1:0]  right,
	input  logic signed [31:0]           add_value,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic signed [63:0]           answer,
	output logic                         bad_range
);

	localparam logic [2:0] ST_CLR    = 3'd0;
	localparam logic [2:0] ST_IDLE   = 3'd1;
	localparam logic [2:0] ST_UPD_RD = 3'd2;
	localparam logic [2:0] ST_UPD_WR = 3'd3;
	localparam logic [2:0] ST_Q_RD   = 3'd4;
	localparam logic [2:0] ST_Q_ACC  = 3'd5;
	localparam logic [2:0] ST_MUL    = 3'd6;
	localparam logic [2:0] ST_OUT    = 3'd7;

	localparam int AW = lrast_pkg::ADDR_W;
	localparam int NW = lrast_pkg::N_W;
	localparam int SW = lrast_pkg::SUM_W;
	localparam int IDX_W_T = lrast_pkg::IDX_W;

	logic [2:0]            st_q;
	logic [AW-1:0]         clr_q;
	logic [NW-1:0]         n_q;
	logic [lrast_pkg::IDX_W-1:0] l_q, r_q;
	logic signed [31:0]    x_q;
	logic [NW-1:0]         pos_q;
	logic                  phase_q;
	logic [SW-1:0]         d1_q, d2_q, acc1_q, acc2_q, mcand_q, prod_q, ans_q;
	logic [NW-1:0]         mplier_q;
	logic                  bad_q;

	logic                  ram_we;
	logic [AW-1:0]         ram_addr;
	logic [2*SW-1:0]       ram_wdata, ram_rdata;

	logic [NW-1:0]         lowbit;
	logic [NW:0]           pos_up;
	logic [NW:0]           pos_r2;
	logic [NW-1:0]         r_plus1;
	logic [NW-1:0]         mul_k;
	logic signed [31:0]    mul_x;
	logic [49:0]           mul_p;
	logic [SW-1:0]         mul_ext;
	logic [SW-1:0]         x_ext;
	logic [SW-1:0]         s1, s2, pf;
	logic [NW-1:0]         pos_dn;
	logic [IDX_W_T-1:0]    in_r;
	logic                  in_bad;
	logic [NW-1:0]         cfg_clamp;

	// Fenwick index stepping
	assign lowbit  = pos_q & (~pos_q + NW'(1));
	assign pos_up  = {1'b0, pos_q} + {1'b0, lowbit};
	assign pos_dn  = pos_q - lowbit;
	assign r_plus1 = {1'b0, r_q} + NW'(1);
	assign pos_r2  = {2'b0, r_q} + (NW+1)'(2);

	// signed value times index, shared by both update points
	assign mul_k   = (st_q == ST_IDLE) ? {1'b0, left} : r_plus1;
	assign mul_x   = (st_q == ST_IDLE) ? add_value : x_q;
	assign mul_p   = mul_x * $signed({1'b0, mul_k});
	assign mul_ext = {{(SW-50){mul_p[49]}}, mul_p};
	assign x_ext   = {{(SW-32){x_q[31]}}, x_q};

	// prefix walk accumulators
	assign s1 = acc1_q + ram_rdata[2*SW-1:SW];
	assign s2 = acc2_q + ram_rdata[SW-1:0];
	assign pf = prod_q - acc2_q;

	// input checks
	assign in_r   = (op == lrast_pkg::OP_POINT) ? left : right;
	assign in_bad = (op != lrast_pkg::OP_RSVD) &&
		(({1'b0, left} >= n_q) || ({1'b0, in_r} >= n_q) || (left > in_r));

	assign cfg_clamp = (cfg_data == '0) ? NW'(1) :
		(cfg_data > NW'(lrast_pkg::CAPACITY)) ? NW'(lrast_pkg::CAPACITY) : cfg_data;

	// memory port
	assign ram_we    = (st_q == ST_CLR) || (st_q == ST_UPD_WR);
	assign ram_addr  = (st_q == ST_CLR) ? clr_q : AW'(pos_q);
	assign ram_wdata = (st_q == ST_CLR) ? '0 :
		{ram_rdata[2*SW-1:SW] + d1_q, ram_rdata[SW-1:0] + d2_q};

	lrast_ram #(
		.WIDTH(2 * SW),
		.DEPTH(lrast_pkg::DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.addr (ram_addr),
		.wdata(ram_wdata),
		.rdata(ram_rdata)
	);

	assign cfg_ready = 1'b1;
	assign in_ready  = (st_q == ST_IDLE);
	assign out_valid = (st_q == ST_OUT);
	assign answer    = ans_q;
	assign bad_range = bad_q;

	// control sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q  <= ST_CLR;
			clr_q <= '0;
			n_q   <= NW'(lrast_pkg::CAPACITY);
		end else if (cfg_valid && cfg_ready) begin
			st_q  <= ST_CLR;
			clr_q <= '0;
			n_q   <= cfg_clamp;
		end else begin
			unique case (st_q)
				ST_CLR: begin
					clr_q <= clr_q + AW'(1);
					if (clr_q == AW'(lrast_pkg::DEPTH - 1)) begin
						st_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (in_valid) begin
						if (in_bad || op == lrast_pkg::OP_RSVD) begin
							st_q <= ST_OUT;
						end else if (op == lrast_pkg::OP_ADD) begin
							st_q <= ST_UPD_RD;
						end else begin
							st_q <= ST_Q_RD;
						end
					end
				end
				ST_UPD_RD: st_q <= ST_UPD_WR;
				ST_UPD_WR: begin
					if (pos_up <= {1'b0, n_q}) begin
						st_q <= ST_UPD_RD;
					end else if (!phase_q && pos_r2 <= {1'b0, n_q}) begin
						st_q <= ST_UPD_RD;
					end else begin
						st_q <= ST_OUT;
					end
				end
				ST_Q_RD: st_q <= ST_Q_ACC;
				ST_Q_ACC: begin
					st_q <= (pos_dn != '0) ? ST_Q_RD : ST_MUL;
				end
				ST_MUL: begin
					if (mplier_q == '0) begin
						st_q <= (!phase_q && l_q != '0) ? ST_Q_RD : ST_OUT;
					end
				end
				ST_OUT: begin
					if (out_ready) begin
						st_q <= ST_IDLE;
					end
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		unique case (st_q)
			ST_IDLE: begin
				l_q     <= left;
				r_q     <= in_r;
				x_q     <= add_value;
				bad_q   <= in_bad;
				ans_q   <= '0;
				phase_q <= 1'b0;
				acc1_q  <= '0;
				acc2_q  <= '0;
				d1_q    <= {{(SW-32){add_value[31]}}, add_value};
				d2_q    <= mul_ext;
				pos_q   <= (op == lrast_pkg::OP_ADD) ? ({1'b0, left} + NW'(1)) :
					({1'b0, in_r} + NW'(1));
			end
			ST_UPD_WR: begin
				if (pos_up <= {1'b0, n_q}) begin
					pos_q <= pos_up[NW-1:0];
				end else if (!phase_q) begin
					phase_q <= 1'b1;
					pos_q   <= pos_r2[NW-1:0];
					d1_q    <= -x_ext;
					d2_q    <= -mul_ext;
				end
			end
			ST_Q_ACC: begin
				acc1_q   <= s1;
				acc2_q   <= s2;
				pos_q    <= pos_dn;
				mcand_q  <= s1;
				prod_q   <= '0;
				mplier_q <= phase_q ? {1'b0, l_q} : r_plus1;
			end
			ST_MUL: begin
				if (mplier_q != '0) begin
					if (mplier_q[0]) begin
						prod_q <= prod_q + mcand_q;
					end
					mcand_q  <= {mcand_q[SW-2:0], 1'b0};
					mplier_q <= mplier_q >> 1;
				end else begin
					ans_q   <= phase_q ? (ans_q - pf) : (ans_q + pf);
					phase_q <= 1'b1;
					acc1_q  <= '0;
					acc2_q  <= '0;
					pos_q   <= {1'b0, l_q};
				end
			end
			default: begin
			end
		endcase
	end

`ifndef SYNTHESIS
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid))
		else $error("input and output handshakes both open");
	a_bad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && bad_range) |-> (answer == '0))
		else $error("bad range beat carries nonzero answer");
	a_cfg_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(cfg_valid && cfg_ready) |=> (!in_ready && clr_q == '0))
		else $error("configuration write did not restart clearing");
	a_n_range: assert property (@(posedge clk) disable iff (!arst_n)
		(n_q != '0) && (n_q <= NW'(lrast_pkg::CAPACITY)))
		else $error("element count out of range");
`endif

endmodule

>>> verif/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Checks the range-add / range-sum store against a Fenwick-tree predictor
// (two trees, linear and offset terms, all sums modulo 2^64). Directed beats
// cover field extremes, every operation, bad ranges and the unknown op.
// Random beats then run under several store sizes, including the
// clamped extremes, with random idling on both channels.
// ----------------------------------------------------------------------------
module testbench;

	localparam int LIMIT_CYCLES = 4000000;
	localparam int DRAIN_CYCLES = 150;

	typedef struct packed {
		logic signed [63:0] answer;
		logic               bad_range;
	} result_t;

	logic                            clk = 1'b0;
	logic                            arst_n = 1'b0;
	logic                            cfg_valid = 1'b0;
	logic                            cfg_ready;
	logic [lrast_pkg::N_W-1:0]       cfg_data = '0;
	logic                            in_valid = 1'b0;
	logic                            in_ready;
	logic [1:0]                      op = lrast_pkg::OP_ADD;
	logic [lrast_pkg::IDX_W-1:0]     left = '0;
	logic [lrast_pkg::IDX_W-1:0]     right = '0;
	logic signed [31:0]              add_value = '0;
	logic                            out_valid;
	logic                            out_ready = 1'b0;
	logic signed [63:0]              answer;
	logic                            bad_range;

	// predictor state: two Fenwick trees, 1-based
	logic [63:0] fw_lin [0:lrast_pkg::CAPACITY+1];
	logic [63:0] fw_off [0:lrast_pkg::CAPACITY+1];
	int          store_n;

	result_t     pending_results [$];
	int          error_count = 0;
	int          checked_count = 0;
	int          cycle_count = 0;
	bit          calm = 1'b0;

	lazy_range_add_segment_tree_top uut (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready),
		.op(op), .left(left), .right(right), .add_value(add_value),
		.out_valid(out_valid), .out_ready(out_ready),
		.answer(answer), .bad_range(bad_range)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// timeout
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > LIMIT_CYCLES) begin
			$display("testbench: errors");
			$finish;
		end
	end

	// receiver stalls
	always @(posedge clk) begin
		out_ready <= calm ? 1'b1 : ($urandom_range(0, 99) >= 29);
	end

	// result checker
	always @(posedge clk) begin
		result_t want;
		if (out_valid && out_ready) begin
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected result beat answer=%0d bad=%0b",
					$time, answer, bad_range);
				error_count++;
			end else begin
				want = pending_results.pop_front();
				checked_count++;
				if (answer !== want.answer) begin
					$display("%0t: answer expected %0d actual %0d",
						$time, want.answer, answer);
					error_count++;
				end
				if (bad_range !== want.bad_range) begin
					$display("%0t: bad_range expected %0b actual %0b",
						$time, want.bad_range, bad_range);
					error_count++;
				end
			end
		end
	end

	function automatic void clear_store();
		for (int i = 0; i <= lrast_pkg::CAPACITY + 1; i++) begin
			fw_lin[i] = '0;
			fw_off[i] = '0;
		end
	endfunction

	function automatic void fw_update(int pos, logic [63:0] lin, logic [63:0] off);
		for (int p = pos; p <= store_n; p += p & -p) begin
			fw_lin[p] += lin;
			fw_off[p] += off;
		end
	endfunction

	// sum of elements 0 .. k-1
	function automatic logic [63:0] prefix_total(int k);
		logic [63:0] s_lin;
		logic [63:0] s_off;
		s_lin = '0;
		s_off = '0;
		for (int p = k; p > 0; p -= p & -p) begin
			s_lin += fw_lin[p];
			s_off += fw_off[p];
		end
		return s_lin * 64'(k) - s_off;
	endfunction

	// expected result of one beat, updating the predicted store
	function automatic result_t predict_beat(logic [1:0] b_op, int l, int r,
		logic signed [31:0] val);
		result_t     res;
		logic [63:0] x;
		res = '0;
		x = 64'(val);
		if (b_op == lrast_pkg::OP_POINT)
			r = l;
		if (b_op != lrast_pkg::OP_RSVD) begin
			if (l >= store_n || r >= store_n || l > r) begin
				res.bad_range = 1'b1;
			end else if (b_op == lrast_pkg::OP_ADD) begin
				fw_update(l + 1, x, x * 64'(l));
				if (r + 2 <= store_n)
					fw_update(r + 2, -x, -(x * 64'(r + 1)));
			end else begin
				res.answer = prefix_total(r + 1) - prefix_total(l);
			end
		end
		return res;
	endfunction

	task automatic send_beat(logic [1:0] b_op, int l, int r, logic signed [31:0] val);
		result_t want_res;
		in_valid  <= 1'b1;
		op        <= b_op;
		left      <= l[lrast_pkg::IDX_W-1:0];
		right     <= r[lrast_pkg::IDX_W-1:0];
		add_value <= val;
		do @(posedge clk); while (!in_ready);
		want_res = predict_beat(b_op, l, r, val);
		pending_results = {pending_results, want_res};
		if (!calm && $urandom_range(0, 99) < 29) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
	endtask

	task automatic wait_drain();
		in_valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_size(int value);
		wait_drain();
		cfg_valid <= 1'b1;
		cfg_data  <= value[lrast_pkg::N_W-1:0];
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		store_n = (value < 1) ? 1 :
			(value > lrast_pkg::CAPACITY) ? lrast_pkg::CAPACITY : value;
		clear_store();
	endtask

	task automatic random_beats(int count);
		int l, r, pick;
		logic signed [31:0] val;
		logic [1:0] b_op;
		for (int i = 0; i < count; i++) begin
			calm = (i >= count / 3) && (i < count / 3 + 60);
			if (i == count / 2)
				wait_drain();
			pick = $urandom_range(0, 99);
			l = $urandom_range(0, store_n - 1);
			r = $urandom_range(0, store_n - 1);
			if (l > r) begin
				int t;
				t = l; l = r; r = t;
			end
			if ($urandom_range(0, 3) == 0)
				r = l + $urandom_range(0, 3);
			if (r >= store_n)
				r = store_n - 1;
			val = $urandom;
			if ($urandom_range(0, 9) == 0)
				val = $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
			if (pick < 40) b_op = lrast_pkg::OP_ADD;
			else if (pick < 65) b_op = lrast_pkg::OP_POINT;
			else if (pick < 95) b_op = lrast_pkg::OP_SUM;
			else begin
				// noise: broken ranges and the unknown op
				b_op = 2'($urandom_range(0, 3));
				l = $urandom_range(0, 65535);
				r = $urandom_range(0, 65535);
			end
			send_beat(b_op, l, r, val);
		end
		calm = 1'b0;
	endtask

	task automatic test_full_store_extremes();
		send_beat(lrast_pkg::OP_ADD, 0, 65535, 32'sh7fffffff);
		send_beat(lrast_pkg::OP_SUM, 0, 65535, 0);
		send_beat(lrast_pkg::OP_ADD, 65535, 65535, 32'sh80000000);
		send_beat(lrast_pkg::OP_POINT, 65535, 0, 0);
		send_beat(lrast_pkg::OP_POINT, 0, 12345, 0);
		send_beat(lrast_pkg::OP_ADD, 100, 40000, -1);
		send_beat(lrast_pkg::OP_SUM, 99, 40001, 0);
		send_beat(lrast_pkg::OP_SUM, 65535, 65535, 0);
		// left beyond right
		send_beat(lrast_pkg::OP_SUM, 10, 9, 0);
		send_beat(lrast_pkg::OP_ADD, 65535, 0, 5);
		// unknown op
		send_beat(lrast_pkg::OP_RSVD, 3, 7, 9);
		// many full adds of the largest value, then a sum of the whole store
		for (int i = 0; i < 6; i++)
			send_beat(lrast_pkg::OP_ADD, 0, 65535, 32'sh7fffffff);
		send_beat(lrast_pkg::OP_SUM, 0, 65535, 0);
	endtask

	task automatic test_single_element();
		write_size(0);
		send_beat(lrast_pkg::OP_ADD, 0, 0, 32'sh80000000);
		send_beat(lrast_pkg::OP_POINT, 0, 0, 0);
		send_beat(lrast_pkg::OP_POINT, 1, 0, 0);
		send_beat(lrast_pkg::OP_SUM, 0, 1, 0);
		send_beat(lrast_pkg::OP_SUM, 0, 0, 0);
		random_beats(40);
	endtask

	task automatic test_small_store();
		write_size(17);
		random_beats(500);
	endtask

	task automatic test_full_store_random();
		write_size(131071);
		random_beats(650);
	endtask

	task automatic test_mid_store();
		write_size(200);
		random_beats(500);
	endtask

	initial begin
		store_n = lrast_pkg::CAPACITY;
		clear_store();
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_full_store_extremes();
		test_single_element();
		test_small_store();
		test_full_store_random();
		test_mid_store();
		wait_drain();
		$display("covered add, point and sum beats, bad ranges and the unknown op,");
		$display("store sizes 1, 17, 200 and 65536; %0d results checked", checked_count);
		if (error_count == 0 && pending_results.size() == 0) begin
			$display("testbench: clean");
		end else begin
			$display("testbench: errors");
		end
		$finish;
	end

endmodule
